@@ rtl/core/did_pkg.sv @@
// did_pkg: shared types and codes for the delta instruction decoder
// used by the decode step, the result register and the top level
`default_nettype none
package did_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned BaseWidth   = 32;
   localparam int unsigned SizeWidth   = 24;
   localparam int unsigned VarintWidth = 64;

   localparam logic [1:0] KindLiteral = 2'd0;
   localparam logic [1:0] KindCopy    = 2'd1;
   localparam logic [1:0] KindHeader  = 2'd2;
   localparam logic [1:0] KindError   = 2'd3;

   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrTruncated = 3'd1;
   localparam logic [2:0] ErrReserved  = 3'd2;
   localparam logic [2:0] ErrRange     = 3'd3;
   localparam logic [2:0] ErrVarint    = 3'd4;

   localparam logic [6:0] VarintShiftLimit = 7'd70;
   localparam logic [6:0] VarintStep       = 7'd7;
   localparam logic [SizeWidth-1:0] ZeroSizeCopy = 24'h010000;

   typedef struct packed {
      logic [1:0]             kind;
      logic [ByteWidth-1:0]   literal_byte;
      logic [BaseWidth-1:0]   copy_start;
      logic [SizeWidth-1:0]   copy_len;
      logic [VarintWidth-1:0] src_bytes;
      logic [VarintWidth-1:0] tgt_bytes;
      logic [2:0]             error_code;
      logic                   last;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/delta_instruction_decoder_core.sv @@
// delta_instruction_decoder_core: top level of the delta instruction decoder
// depends on did_pkg, did_decode and did_rsp_reg
`default_nettype none
// Takes one delta byte per beat and emits at most one result per byte: the
// header sizes, a copy command, a literal byte or an error. A byte is
// registered on entry, decoded in a single pass in the next cycle and its
// result lands in the output register, so one byte per clock is sustained
// while the output is free, and rsp_valid rises once that result is loaded.
// Bytes that cause no result still pass through the input register. base_length
// is written through csr_ and is used as is by every copy range check.
module delta_instruction_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_delta_byte,
   input  wire logic        req_end_of_delta,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_kind,
   output      logic [7:0]  rsp_literal_byte,
   output      logic [31:0] rsp_copy_offset,
   output      logic [23:0] rsp_copy_size,
   output      logic [63:0] rsp_source_size,
   output      logic [63:0] rsp_target_size,
   output      logic [2:0]  rsp_error_code,
   output      logic        rsp_last
);

   logic [31:0]      base_length_ff;
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_end_ff;
   logic             slot_free;
   logic             advance;
   logic             has_result;
   did_pkg::rsp_type result;
   did_pkg::rsp_type rsp_data;

   assign advance   = in_valid_ff && slot_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_valid && req_ready) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= '0;
         in_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) base_length_ff <= csr_write_data;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_delta_byte;
         in_end_ff  <= req_end_of_delta;
      end
   end

   did_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .delta_byte   (in_byte_ff),
      .end_of_delta (in_end_ff),
      .base_length  (base_length_ff),
      .has_result   (has_result),
      .result       (result)
   );

   did_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .load_data (result),
      .slot_free (slot_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_literal_byte = rsp_data.literal_byte;
   assign rsp_copy_offset  = rsp_data.copy_start;
   assign rsp_copy_size    = rsp_data.copy_len;
   assign rsp_source_size  = rsp_data.src_bytes;
   assign rsp_target_size  = rsp_data.tgt_bytes;
   assign rsp_error_code   = rsp_data.error_code;
   assign rsp_last         = rsp_data.last;

endmodule
`default_nettype wire

@@ rtl/core/did_decode.sv @@
// did_decode: per-beat decode of delta bytes, holds the parse state
// depends on did_pkg for the result struct and codes
`default_nettype none
module did_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [did_pkg::ByteWidth-1:0] delta_byte,
   input  wire logic                          end_of_delta,
   input  wire logic [did_pkg::BaseWidth-1:0] base_length,
   output      logic                          has_result,
   output      did_pkg::rsp_type              result
);

   typedef enum logic [2:0] {
      PH_SRC, PH_TGT, PH_CMD, PH_COPY, PH_INSERT, PH_DISCARD
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [did_pkg::VarintWidth-1:0]   acc_ff, acc_in;
   logic [6:0]                        shift_ff, shift_in;
   logic [did_pkg::VarintWidth-1:0]   held_src_ff, held_src_in;
   logic [6:0]                        mask_ff, mask_in;
   logic [did_pkg::BaseWidth-1:0]     offset_ff, offset_in;
   logic [did_pkg::SizeWidth-1:0]     size_ff, size_in;
   logic [6:0]                        remain_ff, remain_in;

   logic [did_pkg::VarintWidth-1:0]   acc_next;
   logic [2:0]                        idx;
   logic [2:0]                        err;
   logic [did_pkg::SizeWidth-1:0]     eff_size;
   logic [did_pkg::BaseWidth:0]       copy_end;
   logic                              finish;
   logic [did_pkg::BaseWidth-1:0]     fin_offset;
   logic [did_pkg::SizeWidth-1:0]     fin_size;
   did_pkg::rsp_type                  res;
   logic                              res_valid;

   assign acc_next = acc_ff
      | ({{(did_pkg::VarintWidth-7){1'b0}}, delta_byte[6:0]} << shift_ff[5:0]);

   // lowest pending operand byte
   always_comb begin
      idx = 3'd0;
      for (int i = 6; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = 3'(i);
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      shift_in    = shift_ff;
      held_src_in = held_src_ff;
      mask_in     = mask_ff;
      offset_in   = offset_ff;
      size_in     = size_ff;
      remain_in   = remain_ff;
      err         = did_pkg::ErrNone;
      finish      = 1'b0;
      fin_offset  = offset_ff;
      fin_size    = size_ff;
      res         = '0;
      res_valid   = 1'b0;

      case (phase_ff)
         PH_SRC, PH_TGT: begin
            if (shift_ff >= did_pkg::VarintShiftLimit) begin
               err = did_pkg::ErrVarint;
            end else begin
               acc_in   = acc_next;
               shift_in = shift_ff + did_pkg::VarintStep;
               if (delta_byte[7]) begin
                  if (end_of_delta) err = did_pkg::ErrTruncated;
               end else if (phase_ff == PH_SRC) begin
                  held_src_in = acc_next;
                  acc_in      = '0;
                  shift_in    = '0;
                  phase_in    = PH_TGT;
                  if (end_of_delta) err = did_pkg::ErrTruncated;
               end else begin
                  res.kind      = did_pkg::KindHeader;
                  res.src_bytes = held_src_ff;
                  res.tgt_bytes = acc_next;
                  res.last      = end_of_delta;
                  res_valid     = 1'b1;
                  acc_in        = '0;
                  shift_in      = '0;
                  phase_in      = PH_CMD;
               end
            end
         end
         PH_CMD: begin
            if (delta_byte[7]) begin
               mask_in    = delta_byte[6:0];
               offset_in  = '0;
               size_in    = '0;
               fin_offset = '0;
               fin_size   = '0;
               if (delta_byte[6:0] == 7'd0) begin
                  finish = 1'b1;
               end else if (end_of_delta) begin
                  err = did_pkg::ErrTruncated;
               end else begin
                  phase_in = PH_COPY;
               end
            end else if (delta_byte != '0) begin
               remain_in = delta_byte[6:0];
               if (end_of_delta) err = did_pkg::ErrTruncated;
               else phase_in = PH_INSERT;
            end else begin
               err = did_pkg::ErrReserved;
            end
         end
         PH_COPY: begin
            case (idx)
               3'd0: fin_offset[7:0]   = delta_byte;
               3'd1: fin_offset[15:8]  = delta_byte;
               3'd2: fin_offset[23:16] = delta_byte;
               3'd3: fin_offset[31:24] = delta_byte;
               3'd4: fin_size[7:0]     = delta_byte;
               3'd5: fin_size[15:8]    = delta_byte;
               3'd6: fin_size[23:16]   = delta_byte;
               default: ;
            endcase
            offset_in = fin_offset;
            size_in   = fin_size;
            mask_in   = mask_ff & ~(7'd1 << idx);
            if (mask_in == 7'd0) begin
               finish = 1'b1;
            end else if (end_of_delta) begin
               err = did_pkg::ErrTruncated;
            end
         end
         PH_INSERT: begin
            if (remain_ff > 7'd1 && end_of_delta) begin
               err = did_pkg::ErrTruncated;
            end else begin
               res.kind         = did_pkg::KindLiteral;
               res.literal_byte = delta_byte;
               res.last         = end_of_delta;
               res_valid        = 1'b1;
               remain_in        = remain_ff - 7'd1;
               if (remain_in == 7'd0) phase_in = PH_CMD;
            end
         end
         default: ;
      endcase

      eff_size = (fin_size == '0) ? did_pkg::ZeroSizeCopy : fin_size;
      copy_end = {1'b0, fin_offset} + {{(did_pkg::BaseWidth+1-did_pkg::SizeWidth){1'b0}},
                 eff_size};
      if (finish) begin
         phase_in = PH_CMD;
         if (copy_end > {1'b0, base_length}) begin
            err = did_pkg::ErrRange;
         end else begin
            res.kind       = did_pkg::KindCopy;
            res.copy_start = fin_offset;
            res.copy_len   = eff_size;
            res.last       = end_of_delta;
            res_valid      = 1'b1;
         end
      end

      if (err != did_pkg::ErrNone || end_of_delta) begin
         phase_in    = PH_SRC;
         acc_in      = '0;
         shift_in    = '0;
         held_src_in = '0;
         mask_in     = '0;
         offset_in   = '0;
         size_in     = '0;
         remain_in   = '0;
      end
      if (err != did_pkg::ErrNone) begin
         res            = '0;
         res.kind       = did_pkg::KindError;
         res.error_code = err;
         res.last       = 1'b1;
         res_valid      = 1'b1;
         if (!end_of_delta) phase_in = PH_DISCARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SRC;
         acc_ff      <= '0;
         shift_ff    <= '0;
         held_src_ff <= '0;
         mask_ff     <= '0;
         offset_ff   <= '0;
         size_ff     <= '0;
         remain_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         shift_ff    <= shift_in;
         held_src_ff <= held_src_in;
         mask_ff     <= mask_in;
         offset_ff   <= offset_in;
         size_ff     <= size_in;
         remain_ff   <= remain_in;
      end
   end

   assign has_result = res_valid;
   assign result     = res;

endmodule
`default_nettype wire

@@ rtl/core/did_rsp_reg.sv @@
// did_rsp_reg: result register on the rsp side of the decoder
// depends on did_pkg for the result struct
`default_nettype none
module did_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire did_pkg::rsp_type  load_data,
   output      logic              slot_free,
   input  wire logic              rsp_ready,
   output      logic              rsp_valid,
   output      did_pkg::rsp_type  rsp_data
);

   logic             valid_ff, valid_in;
   did_pkg::rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire
